@@ rtl/dmc_pkg.sv @@
`default_nettype none

package dmc_pkg;

    // Geometry
    localparam int MAX_SETS    = 1024;
    localparam int SET_W       = $clog2(MAX_SETS);
    localparam int DIV_W       = $clog2(MAX_SETS + 1);
    localparam int ADDR_W      = 64;
    localparam int LINE_LOG2   = 6;
    localparam int TAG_W       = ADDR_W - LINE_LOG2;
    localparam int CNT_W       = 64;
    localparam int CFG_W       = 11;
    localparam int EXT_W       = (CFG_W > DIV_W) ? CFG_W : DIV_W;
    localparam int STEP_W      = $clog2(TAG_W);
    localparam int ENTRY_W     = TAG_W + 1;

    localparam logic [CFG_W-1:0] SET_COUNT_RESET = CFG_W'(1024);

endpackage

`default_nettype wire

@@ rtl/dmc_ram.sv @@
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/direct_mapped_cache_tag_model.sv @@
`default_nettype none

// Direct-mapped cache tag model, 64-byte lines.
//
// Command channel: present i_byte_address and raise start; the item is taken
// at the edge where start is high and busy is low. Exactly one result follows:
// o_result_valid is high for one cycle with o_hit, o_access_total and
// o_miss_total. The receiver cannot stall; the result is gone after that cycle.
//
// The result strobe is registered out of the compare step, and busy falls in the
// strobe cycle, so the next item can be taken then and not before. The time is set by
// the serial remainder unit (one bit of the 58-bit block address a cycle), followed
// by the tag RAM read and then the compare and write-back.
//
// Config channel: i_cfg_valid/o_cfg_ready carries set_count (11 bits). Zero is
// taken as one set, values above 1024 as 1024. The effective count is latched
// when an item is taken. No flush on change.
//
// Reset (synchronous, active low): counters clear, set_count returns to 1024,
// then a clearing pass writes every tag RAM entry invalid, one entry a cycle,
// with busy high. Config writes are taken during the pass.

module direct_mapped_cache_tag_model
    import dmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ADDR_W-1:0] i_byte_address,
    output logic                   o_result_valid,
    output logic                   o_hit,
    output logic [CNT_W-1:0]       o_access_total,
    output logic [CNT_W-1:0]       o_miss_total,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CMP
    } t_state;

    t_state             r_state,     n_state;
    logic [SET_W-1:0]   r_clr,       n_clr;
    logic [STEP_W-1:0]  r_step,      n_step;
    logic [TAG_W-1:0]   r_block,     n_block;   // shifts out MSB first
    logic [TAG_W-1:0]   r_tag,       n_tag;     // full block address
    logic [SET_W-1:0]   r_rem,       n_rem;
    logic [DIV_W-1:0]   r_div_n,     n_div_n;
    logic [CFG_W-1:0]   r_set_count, n_set_count;
    logic [CNT_W-1:0]   r_access,    n_access;
    logic [CNT_W-1:0]   r_miss,      n_miss;
    logic               r_res_vld,   n_res_vld;
    logic               r_hit,       n_hit;

    // Tag RAM port signals
    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // Remainder step and effective set count
    logic [SET_W:0]     rem_shift;
    logic [SET_W:0]     rem_sub;
    logic [EXT_W-1:0]   cfg_ext;
    logic [DIV_W-1:0]   eff_sets;
    logic               line_hit;

    dmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rem),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cfg_ext = EXT_W'(r_set_count);
        if (cfg_ext == '0) begin
            eff_sets = DIV_W'(1);
        end else if (cfg_ext > EXT_W'(MAX_SETS)) begin
            eff_sets = DIV_W'(MAX_SETS);
        end else begin
            eff_sets = DIV_W'(cfg_ext);
        end
    end

    // Restoring remainder: the remainder stays below the divisor, so one
    // compare and subtract per bit keeps it in range.
    assign rem_shift = {r_rem, r_block[TAG_W-1]};
    assign rem_sub   = rem_shift - (SET_W+1)'(r_div_n);

    // Entry layout: {valid, tag}
    assign line_hit = ram_rdata[ENTRY_W-1] && (ram_rdata[TAG_W-1:0] == r_tag);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_step      = r_step;
        n_block     = r_block;
        n_tag       = r_tag;
        n_rem       = r_rem;
        n_div_n     = r_div_n;
        n_set_count = r_set_count;
        n_access    = r_access;
        n_miss      = r_miss;
        n_res_vld   = 1'b0;
        n_hit       = r_hit;
        ram_we      = 1'b0;
        ram_waddr   = r_rem;
        ram_wdata   = {1'b1, r_tag};

        if (i_cfg_valid) begin
            n_set_count = i_cfg_data;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + SET_W'(1);
                if (r_clr == SET_W'(MAX_SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_block = i_byte_address[ADDR_W-1:LINE_LOG2];
                    n_tag   = i_byte_address[ADDR_W-1:LINE_LOG2];
                    n_rem   = '0;
                    n_step  = '0;
                    n_div_n = eff_sets;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_shift >= (SET_W+1)'(r_div_n)) begin
                    n_rem = rem_sub[SET_W-1:0];
                end else begin
                    n_rem = rem_shift[SET_W-1:0];
                end
                n_block = {r_block[TAG_W-2:0], 1'b0};
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(TAG_W - 1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // RAM address is r_rem; data is back next cycle
                n_state = S_CMP;
            end
            S_CMP: begin
                n_access  = r_access + CNT_W'(1);
                n_hit     = line_hit;
                n_res_vld = 1'b1;
                if (!line_hit) begin
                    n_miss = r_miss + CNT_W'(1);
                    ram_we = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_set_count <= SET_COUNT_RESET;
            r_access    <= '0;
            r_miss      <= '0;
            r_res_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_set_count <= n_set_count;
            r_access    <= n_access;
            r_miss      <= n_miss;
            r_res_vld   <= n_res_vld;
        end
        r_step  <= n_step;
        r_block <= n_block;
        r_tag   <= n_tag;
        r_rem   <= n_rem;
        r_div_n <= n_div_n;
        r_hit   <= n_hit;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_vld;
    assign o_hit          = r_hit;
    assign o_access_total = r_access;
    assign o_miss_total   = r_miss;

    // A result strobe lasts one cycle and the block is free while it shows
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(r_state) == S_CMP))
        else $error("result strobe outside compare step");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // Each result counts exactly one access
    a_access_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(i_rst_n)) |-> (r_access == $past(r_access) + CNT_W'(1)))
        else $error("access count not stepped by one");

    // A miss bumps the miss count, a hit leaves it
    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(i_rst_n)) |->
            (r_miss == $past(r_miss) + CNT_W'(!o_hit)))
        else $error("miss count out of step with hit flag");

endmodule

`default_nettype wire
